/* hdl/gwr_pkg.sv */
// ----------------------------------------------------------------------------
// gwr_pkg: shared types and constants of the congestion grid router
// Field widths, action and register codes, and the walker request types.
// ----------------------------------------------------------------------------
package gwr_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int COST_BITS_DEF = 16;

    localparam int COORD_W  = 8;
    localparam int ACTION_W = 2;
    localparam int RND_W    = 16;
    localparam int CNT_W    = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int MAXC_W   = 17;
    localparam int SUMC_W   = 25;
    localparam int CELL_W   = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [ACTION_W-1:0] ACT_PLACE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REROUTE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   start;
        logic   step;
        logic   dir;
        t_coord bend;
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
    } t_walk_req;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_walk_pos;

endpackage

/* hdl/gwr_req_if.sv */
// ----------------------------------------------------------------------------
// gwr_req_if: request channel
// Carries one routing action with its coordinates.
// ----------------------------------------------------------------------------
interface gwr_req_if;
    import gwr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    t_coord              start_x;
    t_coord              start_y;
    t_coord              end_x;
    t_coord              end_y;
    logic                old_direction;
    t_coord              old_bend;
    logic                explore;
    logic [RND_W-1:0]    random_value;

    modport source (output valid, action, start_x, start_y, end_x, end_y,
                    old_direction, old_bend, explore, random_value, input ready);
    modport sink (input valid, action, start_x, start_y, end_x, end_y,
                  old_direction, old_bend, explore, random_value, output ready);
endinterface

/* hdl/gwr_res_if.sv */
// ----------------------------------------------------------------------------
// gwr_res_if: result channel
// Carries the chosen route, its costs, a read cell and the status.
// ----------------------------------------------------------------------------
interface gwr_res_if;
    import gwr_pkg::*;

    logic              valid;
    logic              ready;
    logic              new_direction;
    t_coord            new_bend;
    logic [MAXC_W-1:0] route_max_cost;
    logic [SUMC_W-1:0] route_total_cost;
    logic [CELL_W-1:0] cell_value;
    logic              status;

    modport source (output valid, new_direction, new_bend, route_max_cost,
                    route_total_cost, cell_value, status, input ready);
    modport sink (input valid, new_direction, new_bend, route_max_cost,
                  route_total_cost, cell_value, status, output ready);
endinterface

/* hdl/gwr_cfg_if.sv */
// ----------------------------------------------------------------------------
// gwr_cfg_if: configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
interface gwr_cfg_if;
    import gwr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/gwr_walker.sv */
// ----------------------------------------------------------------------------
// gwr_walker: route cell sequencer
// Steps through the cells of a two-bend route, one cell per step request.
// ----------------------------------------------------------------------------
module gwr_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gwr_pkg::t_walk_req i_req,
    output gwr_pkg::t_walk_pos o_pos
);
    import gwr_pkg::*;

    t_coord     r_px, r_py;
    logic [1:0] r_phase;

    logic   reach0, reach1, reach2;
    logic   move, move_x;
    t_coord target;
    logic [1:0] n_phase;
    t_coord cur;

    // Phase 0 runs to the bend, phase 1 crosses to the far line, phase 2
    // runs to the end cell.  A phase whose target is already met is skipped.
    always_comb begin
        if (!i_req.dir) begin
            reach0 = (r_px == i_req.bend);
            reach1 = (r_py == i_req.y2);
            reach2 = (r_px == i_req.x2);
        end else begin
            reach0 = (r_py == i_req.bend);
            reach1 = (r_px == i_req.x2);
            reach2 = (r_py == i_req.y2);
        end
        move    = 1'b1;
        n_phase = r_phase;
        if (r_phase == 2'd0 && !reach0) begin
            n_phase = 2'd0;
            move_x  = !i_req.dir;
            target  = i_req.bend;
        end else if (r_phase != 2'd2 && !reach1) begin
            n_phase = 2'd1;
            move_x  = i_req.dir;
            target  = i_req.dir ? i_req.x2 : i_req.y2;
        end else begin
            n_phase = 2'd2;
            move_x  = !i_req.dir;
            target  = i_req.dir ? i_req.y2 : i_req.x2;
            move    = !reach2;
        end
        cur = move_x ? r_px : r_py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (i_req.start) begin
            r_phase <= 2'd0;
        end else if (i_req.step && move) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_px <= i_req.x1;
            r_py <= i_req.y1;
        end else if (i_req.step && move) begin
            if (move_x) begin
                r_px <= (cur < target) ? cur + 1'b1 : cur - 1'b1;
            end else begin
                r_py <= (cur < target) ? cur + 1'b1 : cur - 1'b1;
            end
        end
    end

    assign o_pos.x    = r_px;
    assign o_pos.y    = r_py;
    assign o_pos.last = !move;
endmodule

/* hdl/gwr_mod.sv */
// ----------------------------------------------------------------------------
// gwr_mod: serial remainder unit
// Restoring division, one dividend bit per cycle, giving the remainder.
// ----------------------------------------------------------------------------
module gwr_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gwr_pkg::RND_W-1:0] i_dividend,
    input  logic [gwr_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [gwr_pkg::CNT_W-1:0] o_rem
);
    import gwr_pkg::*;

    localparam int STEP_W = $clog2(RND_W);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [RND_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_div, r_rem;
    logic [CNT_W:0]    trial;

    assign trial = {r_rem, r_dvd[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= STEP_W'(RND_W - 1);
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= CNT_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= CNT_W'(trial);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* hdl/grid_wire_reroute.sv */
// ----------------------------------------------------------------------------
// grid_wire_reroute: congestion grid for two-bend wire routing
// Keeps per-cell wire counts in one memory and places, reroutes or reads.
// ----------------------------------------------------------------------------
// Requests arrive on i_req; each gives exactly one result on o_res.  The
// configuration channel i_cfg sets the grid width and height in use and is
// always ready.  The user must write it only while no request is in
// flight; the block itself does not enforce this.  After reset the grid
// memory of 2**(2*clog2(GRID_SIDE)) cells (65536 by default) is cleared
// one cell per cycle; i_req is held off until that pass ends.
// Each route cell passes through S_WADDR (memory read), then S_WDATA
// (update), and each route walk opens with the set-up state S_WINIT.  A
// read passes through S_RD_ADDR, then S_RD_DATA.  A place walks the route
// twice.  A reroute walks the old route, then every candidate bend, then
// the chosen route twice; when exploring it walks the old route, waits in
// S_MOD for the serial remainder, then walks the chosen route twice.
// The result sits in an output register; a new request is taken while it
// waits, and a finished result waits in turn until o_res is free.
// ----------------------------------------------------------------------------
module grid_wire_reroute #(
    parameter int GRID_SIDE = gwr_pkg::GRID_SIDE_DEF,
    parameter int COST_BITS = gwr_pkg::COST_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gwr_req_if.sink   i_req,
    gwr_res_if.source o_res,
    gwr_cfg_if.sink   i_cfg
);
    import gwr_pkg::*;

    localparam int SIDE_BITS = $clog2(GRID_SIDE);
    localparam int ADDR_W    = 2 * SIDE_BITS;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int LIM_W     = (SIDE_BITS + 1 > CFG_W) ? SIDE_BITS + 1 : CFG_W;
    localparam int VAL_W     = COST_BITS + 1;
    localparam int SUM_W     = VAL_W + $clog2(3 * GRID_SIDE + 2);
    localparam logic [COST_BITS-1:0] CELL_MAX = {COST_BITS{1'b1}};

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_RD_ADDR = 4'd3;
    localparam logic [3:0] S_RD_DATA = 4'd4;
    localparam logic [3:0] S_WINIT   = 4'd5;
    localparam logic [3:0] S_WADDR   = 4'd6;
    localparam logic [3:0] S_WDATA   = 4'd7;
    localparam logic [3:0] S_MOD     = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;

    localparam logic [1:0] P_REMOVE = 2'd0;
    localparam logic [1:0] P_CAND   = 2'd1;
    localparam logic [1:0] P_SCORE  = 2'd2;
    localparam logic [1:0] P_ADD    = 2'd3;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase;
    logic [CFG_W-1:0] r_width, r_height;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [ACTION_W-1:0] r_act;
    t_coord r_x1, r_y1, r_x2, r_y2, r_obend;
    logic   r_odir, r_explore;
    logic [RND_W-1:0] r_rnd;

    logic   r_wdir, r_ndir, r_cand_dir, r_best_dir, r_cand_first;
    t_coord r_wbend, r_nbend, r_cand_bend, r_best_bend;
    logic [VAL_W-1:0] r_mx, r_best_mx, r_res_mx;
    logic [SUM_W-1:0] r_sm, r_best_sm, r_res_sm;
    logic [COST_BITS-1:0] r_res_cell, r_rdata;
    logic r_res_status;

    logic r_o_valid, r_o_dir, r_o_status;
    t_coord r_o_bend;
    logic [MAXC_W-1:0] r_o_mx;
    logic [SUMC_W-1:0] r_o_sm;
    logic [CELL_W-1:0] r_o_cell;

    logic [COST_BITS-1:0] r_mem [DEPTH];

    t_walk_req walk_req;
    t_walk_pos walk_pos;
    logic mod_start, mod_done;
    logic [CNT_W-1:0] mod_rem;

    // ------------------------------------------------------------------
    // Grid limits and the candidate span.
    logic [LIM_W-1:0] w_lim, h_lim;
    logic oob_read, oob_route;
    logic sx_neg, sy_neg;
    t_coord nx, ny;
    logic [CNT_W-1:0] cnt;

    always_comb begin
        w_lim = (LIM_W'(r_width) > LIM_W'(GRID_SIDE)) ? LIM_W'(GRID_SIDE)
                                                       : LIM_W'(r_width);
        h_lim = (LIM_W'(r_height) > LIM_W'(GRID_SIDE)) ? LIM_W'(GRID_SIDE)
                                                        : LIM_W'(r_height);
        oob_read  = (LIM_W'(r_x1) >= w_lim) || (LIM_W'(r_y1) >= h_lim);
        oob_route = oob_read || (LIM_W'(r_x2) >= w_lim) || (LIM_W'(r_y2) >= h_lim)
                    || (r_odir ? (LIM_W'(r_obend) >= h_lim)
                               : (LIM_W'(r_obend) >= w_lim));
        sx_neg = r_x1 > r_x2;
        sy_neg = r_y1 > r_y2;
        nx     = sx_neg ? r_x1 - r_x2 : r_x2 - r_x1;
        ny     = sy_neg ? r_y1 - r_y2 : r_y2 - r_y1;
        cnt    = CNT_W'(nx) + CNT_W'(ny);
    end

    // ------------------------------------------------------------------
    // Cell update and running cost of the walk.
    logic [VAL_W-1:0] cell_val, acc_mx;
    logic [SUM_W-1:0] acc_sm;
    logic walk_done, cand_better, cand_more;
    logic [ADDR_W-1:0] walk_addr;

    always_comb begin
        cell_val  = VAL_W'(r_rdata) + 1'b1;
        acc_mx    = (cell_val > r_mx) ? cell_val : r_mx;
        acc_sm    = r_sm + SUM_W'(cell_val);
        walk_done = (r_state == S_WDATA) && walk_pos.last;
        walk_addr = {SIDE_BITS'(walk_pos.y), SIDE_BITS'(walk_pos.x)};
        cand_better = r_cand_first || (acc_mx < r_best_mx)
                      || ((acc_mx == r_best_mx) && (acc_sm < r_best_sm));
        cand_more = r_cand_dir ? (r_cand_bend != r_y2)
                               : ((r_cand_bend != r_x2) || (ny != '0));
    end

    // First candidate, the one after the current, and the explored pick.
    logic   init_dir, next_dir, pick_dir;
    t_coord init_bend, next_bend, pick_bend;
    logic [CNT_W-1:0] pick_off;

    always_comb begin
        if (nx != '0) begin
            init_dir  = 1'b0;
            init_bend = sx_neg ? r_x1 - 1'b1 : r_x1 + 1'b1;
        end else begin
            init_dir  = 1'b1;
            init_bend = sy_neg ? r_y1 - 1'b1 : r_y1 + 1'b1;
        end
        if (!r_cand_dir && (r_cand_bend != r_x2)) begin
            next_dir  = 1'b0;
            next_bend = sx_neg ? r_cand_bend - 1'b1 : r_cand_bend + 1'b1;
        end else if (!r_cand_dir) begin
            next_dir  = 1'b1;
            next_bend = sy_neg ? r_y1 - 1'b1 : r_y1 + 1'b1;
        end else begin
            next_dir  = 1'b1;
            next_bend = sy_neg ? r_cand_bend - 1'b1 : r_cand_bend + 1'b1;
        end
        if (mod_rem < CNT_W'(nx)) begin
            pick_dir  = 1'b0;
            pick_off  = mod_rem + 1'b1;
            pick_bend = sx_neg ? COORD_W'(CNT_W'(r_x1) - pick_off)
                               : COORD_W'(CNT_W'(r_x1) + pick_off);
        end else begin
            pick_dir  = 1'b1;
            pick_off  = mod_rem - CNT_W'(nx) + 1'b1;
            pick_bend = sy_neg ? COORD_W'(CNT_W'(r_y1) - pick_off)
                               : COORD_W'(CNT_W'(r_y1) + pick_off);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    logic in_accept, out_free;

    assign in_accept = i_req.valid && i_req.ready;
    assign out_free  = !r_o_valid || o_res.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (&r_clr_addr) n_state = S_IDLE;
            S_IDLE:    if (in_accept) n_state = S_DECODE;
            S_DECODE: begin
                if (r_act == ACT_READ) begin
                    n_state = oob_read ? S_FIN : S_RD_ADDR;
                end else if ((r_act == ACT_PLACE || r_act == ACT_REROUTE)
                             && !oob_route) begin
                    n_state = S_WINIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD_ADDR: n_state = S_RD_DATA;
            S_RD_DATA: n_state = S_FIN;
            S_WINIT:   n_state = S_WADDR;
            S_WADDR:   n_state = S_WDATA;
            S_WDATA: begin
                if (!walk_pos.last) begin
                    n_state = S_WADDR;
                end else if (r_phase == P_ADD) begin
                    n_state = S_FIN;
                end else if (r_phase == P_REMOVE && cnt != '0 && r_explore) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_WINIT;
                end
            end
            S_MOD:     if (mod_done) n_state = S_WINIT;
            S_FIN:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_width    <= CFG_RESET;
            r_height   <= CFG_RESET;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_WIDTH:  r_width  <= i_cfg.data;
                    REG_HEIGHT: r_height <= i_cfg.data;
                    default:    ;
                endcase
            end
            if (r_state == S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_act     <= i_req.action;
            r_x1      <= i_req.start_x;
            r_y1      <= i_req.start_y;
            r_x2      <= i_req.end_x;
            r_y2      <= i_req.end_y;
            r_odir    <= i_req.old_direction;
            r_obend   <= i_req.old_bend;
            r_explore <= i_req.explore;
            r_rnd     <= i_req.random_value;
        end
        case (r_state)
            S_DECODE: begin
                r_res_status <= (r_act == ACT_READ) ? oob_read
                              : ((r_act == ACT_PLACE || r_act == ACT_REROUTE)
                                 && oob_route);
                r_res_cell <= '0;
                r_res_mx   <= '0;
                r_res_sm   <= '0;
                r_ndir     <= 1'b0;
                r_nbend    <= '0;
                if (!oob_route && (r_act == ACT_PLACE || r_act == ACT_REROUTE)) begin
                    r_ndir  <= r_odir;
                    r_nbend <= r_obend;
                end
                r_wdir  <= r_odir;
                r_wbend <= r_obend;
                r_phase <= (r_act == ACT_PLACE) ? P_SCORE : P_REMOVE;
            end
            S_RD_DATA: r_res_cell <= r_rdata;
            S_WINIT: begin
                r_mx <= '0;
                r_sm <= '0;
            end
            S_WDATA: begin
                r_mx <= acc_mx;
                r_sm <= acc_sm;
                if (walk_pos.last) begin
                    case (r_phase)
                        P_REMOVE: begin
                            if (cnt == '0) begin
                                r_phase <= P_SCORE;
                            end else if (!r_explore) begin
                                r_phase      <= P_CAND;
                                r_cand_first <= 1'b1;
                                r_cand_dir   <= init_dir;
                                r_cand_bend  <= init_bend;
                                r_wdir       <= init_dir;
                                r_wbend      <= init_bend;
                            end
                        end
                        P_CAND: begin
                            r_cand_first <= 1'b0;
                            if (cand_better) begin
                                r_best_mx   <= acc_mx;
                                r_best_sm   <= acc_sm;
                                r_best_dir  <= r_cand_dir;
                                r_best_bend <= r_cand_bend;
                            end
                            if (cand_more) begin
                                r_cand_dir  <= next_dir;
                                r_cand_bend <= next_bend;
                                r_wdir      <= next_dir;
                                r_wbend     <= next_bend;
                            end else begin
                                r_phase <= P_SCORE;
                                r_ndir  <= cand_better ? r_cand_dir : r_best_dir;
                                r_nbend <= cand_better ? r_cand_bend : r_best_bend;
                                r_wdir  <= cand_better ? r_cand_dir : r_best_dir;
                                r_wbend <= cand_better ? r_cand_bend : r_best_bend;
                            end
                        end
                        P_SCORE: begin
                            r_res_mx <= acc_mx;
                            r_res_sm <= acc_sm;
                            r_phase  <= P_ADD;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    r_phase <= P_SCORE;
                    r_ndir  <= pick_dir;
                    r_nbend <= pick_bend;
                    r_wdir  <= pick_dir;
                    r_wbend <= pick_bend;
                end
            end
            default: ;
        endcase
        if (r_state == S_FIN && out_free) begin
            r_o_dir    <= r_ndir;
            r_o_bend   <= r_nbend;
            r_o_mx     <= MAXC_W'(r_res_mx);
            r_o_sm     <= SUMC_W'(r_res_sm);
            r_o_cell   <= CELL_W'(r_res_cell);
            r_o_status <= r_res_status;
        end
    end

    // ------------------------------------------------------------------
    // Grid memory: one write and one registered read per cycle.
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [COST_BITS-1:0] mem_wdata;

    always_comb begin
        mem_re    = (r_state == S_WADDR) || (r_state == S_RD_ADDR);
        mem_raddr = (r_state == S_RD_ADDR) ? {SIDE_BITS'(r_y1), SIDE_BITS'(r_x1)}
                                           : walk_addr;
        mem_we    = (r_state == S_CLEAR)
                    || ((r_state == S_WDATA)
                        && (r_phase == P_ADD || r_phase == P_REMOVE));
        mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : walk_addr;
        if (r_state == S_CLEAR) begin
            mem_wdata = '0;
        end else if (r_phase == P_ADD) begin
            mem_wdata = (r_rdata == CELL_MAX) ? r_rdata : r_rdata + 1'b1;
        end else begin
            mem_wdata = (r_rdata == '0) ? r_rdata : r_rdata - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    always_comb begin
        walk_req.start = (r_state == S_WINIT);
        walk_req.step  = (r_state == S_WDATA);
        walk_req.dir   = r_wdir;
        walk_req.bend  = r_wbend;
        walk_req.x1    = r_x1;
        walk_req.y1    = r_y1;
        walk_req.x2    = r_x2;
        walk_req.y2    = r_y2;
    end

    gwr_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (walk_req),
        .o_pos   (walk_pos)
    );

    assign mod_start = walk_done && (r_phase == P_REMOVE) && (cnt != '0) && r_explore;

    gwr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (cnt),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid            = r_o_valid;
    assign o_res.new_direction    = r_o_dir;
    assign o_res.new_bend         = r_o_bend;
    assign o_res.route_max_cost   = r_o_mx;
    assign o_res.route_total_cost = r_o_sm;
    assign o_res.cell_value       = r_o_cell;
    assign o_res.status           = r_o_status;

    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_DECODE)
        else $error("accepted request did not start decoding");

    a_mod_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == S_MOD)
        else $error("remainder finished outside its wait state");

    a_add_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_done && r_phase == P_ADD) |=> r_state == S_FIN)
        else $error("route add did not finish the request");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_FIN)
        else $error("result appeared without a finished request");
endmodule

/* tb/sv/gwr_tb_if.sv */
// ----------------------------------------------------------------------------
// gwr_tb_if: testbench view of the channels
// The channel interfaces are compiled with the RTL; this file only holds the
// request item type that the stimulus and the checker share.
// ----------------------------------------------------------------------------
package gwr_tb_pkg;
    import gwr_pkg::*;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        t_coord              sx;
        t_coord              sy;
        t_coord              ex;
        t_coord              ey;
        logic                odir;
        t_coord              obend;
        logic                explore;
        logic [RND_W-1:0]    rnd;
    } t_route_req;
endpackage

/* tb/sv/gwr_checker.sv */
// ----------------------------------------------------------------------------
// gwr_checker: grid shadow and result comparison
// Watches the request, result and configuration channels, keeps its own copy
// of the congestion grid, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module gwr_checker
    import gwr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gwr_req_if.sink   i_req,
    gwr_res_if.sink   i_res,
    gwr_cfg_if.sink   i_cfg,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = GRID_SIDE_DEF;
    localparam int CELL_TOP = (1 << COST_BITS_DEF) - 1;

    typedef struct packed {
        logic              dir;
        t_coord            bend;
        logic [MAXC_W-1:0] maxc;
        logic [SUMC_W-1:0] sumc;
        logic [CELL_W-1:0] cell_cost;
        logic              status;
    } t_route_res;

    int unsigned shadow_grid [SIDE*SIDE];
    int          cols_in_use;
    int          rows_in_use;
    t_route_res  awaited_results [$];
    longint      walk_max;
    longint      walk_sum;

    // mode: 0 score only, 1 add with saturation, -1 remove with floor at zero
    function automatic void touch_cell(int x, int y, int mode);
        int unsigned c;
        c = shadow_grid[y*SIDE + x];
        if (longint'(c) + 1 > walk_max) walk_max = longint'(c) + 1;
        walk_sum += longint'(c) + 1;
        if (mode > 0 && c < CELL_TOP) shadow_grid[y*SIDE + x] = c + 1;
        else if (mode < 0 && c > 0) shadow_grid[y*SIDE + x] = c - 1;
    endfunction

    function automatic void trace_route(int x1, int y1, int x2, int y2,
                                        int dir, int bend, int mode);
        int a;
        walk_max = 0;
        walk_sum = 0;
        if (dir == 0) begin
            for (a = x1; a != bend; a += (a < bend) ? 1 : -1) touch_cell(a, y1, mode);
            for (a = y1; a != y2; a += (a < y2) ? 1 : -1) touch_cell(bend, a, mode);
            for (a = bend; a != x2; a += (a < x2) ? 1 : -1) touch_cell(a, y2, mode);
        end else begin
            for (a = y1; a != bend; a += (a < bend) ? 1 : -1) touch_cell(x1, a, mode);
            for (a = x1; a != x2; a += (a < x2) ? 1 : -1) touch_cell(a, bend, mode);
            for (a = bend; a != y2; a += (a < y2) ? 1 : -1) touch_cell(x2, a, mode);
        end
        touch_cell(x2, y2, mode);
    endfunction

    function automatic t_route_res route_outcome(gwr_tb_pkg::t_route_req r);
        t_route_res res;
        int x1, y1, x2, y2, nx, ny, sx, sy, cnt, pick, i, d, b, ndir, nbend;
        longint best_max, best_sum;
        res = '0;
        x1 = r.sx; y1 = r.sy; x2 = r.ex; y2 = r.ey;
        if (r.action == ACT_READ) begin
            if (x1 >= cols_in_use || y1 >= rows_in_use) res.status = 1'b1;
            else res.cell_cost = CELL_W'(shadow_grid[y1*SIDE + x1]);
            return res;
        end
        if (r.action != ACT_PLACE && r.action != ACT_REROUTE) return res;
        if (x1 >= cols_in_use || y1 >= rows_in_use || x2 >= cols_in_use ||
            y2 >= rows_in_use ||
            (r.odir == 1'b0 ? r.obend >= cols_in_use : r.obend >= rows_in_use)) begin
            res.status = 1'b1;
            return res;
        end
        ndir = r.odir;
        nbend = r.obend;
        if (r.action == ACT_REROUTE) begin
            nx = (x1 > x2) ? x1 - x2 : x2 - x1;
            ny = (y1 > y2) ? y1 - y2 : y2 - y1;
            sx = (x1 > x2) ? -1 : 1;
            sy = (y1 > y2) ? -1 : 1;
            cnt = nx + ny;
            pick = 0;
            best_max = 0;
            best_sum = 0;
            trace_route(x1, y1, x2, y2, r.odir, r.obend, -1);
            if (cnt > 0) begin
                if (r.explore) pick = r.rnd % cnt;
                else begin
                    for (i = 0; i < cnt; i++) begin
                        d = (i < nx) ? 0 : 1;
                        b = (i < nx) ? x1 + sx*(i+1) : y1 + sy*(i-nx+1);
                        trace_route(x1, y1, x2, y2, d, b, 0);
                        if (i == 0 || walk_max < best_max ||
                            (walk_max == best_max && walk_sum < best_sum)) begin
                            best_max = walk_max;
                            best_sum = walk_sum;
                            pick = i;
                        end
                    end
                end
                if (pick < nx) begin
                    ndir = 0;
                    nbend = x1 + sx*(pick+1);
                end else begin
                    ndir = 1;
                    nbend = y1 + sy*(pick-nx+1);
                end
            end
        end
        trace_route(x1, y1, x2, y2, ndir, nbend, 0);
        res.dir = ndir[0];
        res.bend = nbend[7:0];
        res.maxc = walk_max[MAXC_W-1:0];
        res.sumc = walk_sum[SUMC_W-1:0];
        trace_route(x1, y1, x2, y2, ndir, nbend, 1);
        return res;
    endfunction

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        gwr_tb_pkg::t_route_req r;
        t_route_res want;
        t_route_res got;
        if (!i_rst_n) begin
            cols_in_use <= 256;
            rows_in_use <= 256;
            o_errors <= 0;
            foreach (shadow_grid[k]) shadow_grid[k] = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_WIDTH)
                    cols_in_use <= (i_cfg.data > SIDE) ? SIDE : i_cfg.data;
                else if (i_cfg.index == REG_HEIGHT)
                    rows_in_use <= (i_cfg.data > SIDE) ? SIDE : i_cfg.data;
            end
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.new_direction, i_res.new_bend, i_res.route_max_cost,
                        i_res.route_total_cost, i_res.cell_value, i_res.status};
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch: expected %p, actual %p",
                                 $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // The shadow grid moves on at the request; requests are handled in order, as in the block.
            if (i_req.valid && i_req.ready) begin
                r = '{i_req.action, i_req.start_x, i_req.start_y, i_req.end_x,
                      i_req.end_y, i_req.old_direction, i_req.old_bend,
                      i_req.explore, i_req.random_value};
                awaited_results.push_back(route_outcome(r));
            end
        end
    end
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the congestion grid router
// Drives directed and random place, reroute and read requests over several
// grid sizes, with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import gwr_pkg::*;
    import gwr_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     error_count;
    int     pending;
    longint cycle_count = 0;
    bit     calm_stretch = 1'b0;
    bit     hold_sink = 1'b0;
    int     cols_now = 256;
    int     rows_now = 256;
    int     n;

    gwr_req_if req_ch ();
    gwr_res_if res_ch ();
    gwr_cfg_if cfg_ch ();

    grid_wire_reroute u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    gwr_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch.sink),
        .i_res     (res_ch.sink),
        .i_cfg     (cfg_ch.sink),
        .o_errors  (error_count),
        .o_pending (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 40_000_000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side ready, with random stalls unless held off or in a calm stretch.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) res_ch.ready <= 1'b0;
            else if (calm_stretch) res_ch.ready <= 1'b1;
            else res_ch.ready <= ($urandom_range(99) >= 31);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        if (idx == REG_WIDTH) cols_now = (value > 256) ? 256 : value;
        else rows_now = (value > 256) ? 256 : value;
    endtask

    // The request stays offered after acceptance until the next one, an idle
    // gap or the drain takes its place at the following falling edge.
    task automatic send_request(t_route_req r);
        if (!calm_stretch) begin
            while ($urandom_range(99) < 31) begin
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= r.action;
        req_ch.start_x       <= r.sx;
        req_ch.start_y       <= r.sy;
        req_ch.end_x         <= r.ex;
        req_ch.end_y         <= r.ey;
        req_ch.old_direction <= r.odir;
        req_ch.old_bend      <= r.obend;
        req_ch.explore       <= r.explore;
        req_ch.random_value  <= r.rnd;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Coordinates mostly inside the grid in use, now and then beyond it.
    function automatic t_coord pick_coord(int lim);
        int lo;
        if ($urandom_range(19) == 0) return t_coord'($urandom_range(255));
        lo = $urandom_range(lim - 1);
        return t_coord'(lo);
    endfunction

    function automatic t_route_req random_request(int span);
        t_route_req r;
        int cx, cy;
        r.action  = ($urandom_range(99) < 2) ? ACT_UNUSED :
                    ($urandom_range(2) == 0 ? ACT_PLACE :
                     ($urandom_range(1) ? ACT_REROUTE : ACT_READ));
        r.explore = 1'($urandom_range(1));
        r.rnd     = RND_W'($urandom_range(65535));
        // Short wires keep the reroute search quick; a far corner turns up now and then.
        cx = $urandom_range(cols_now - 1);
        cy = $urandom_range(rows_now - 1);
        r.sx = t_coord'(cx);
        r.sy = t_coord'(cy);
        r.ex = t_coord'(cx + $urandom_range(span) < cols_now ?
                        cx + $urandom_range(span) : cols_now - 1);
        r.ey = t_coord'(cy >= span ? cy - $urandom_range(span) : 0);
        if ($urandom_range(1)) begin
            r.sx = r.ex;
            r.ex = t_coord'(cx);
        end
        if ($urandom_range(15) == 0) r.sx = pick_coord(cols_now);
        if ($urandom_range(15) == 0) r.ey = pick_coord(rows_now);
        r.odir  = 1'($urandom_range(1));
        r.obend = r.odir ? t_coord'($urandom_range(rows_now - 1)) :
                           t_coord'($urandom_range(cols_now - 1));
        if ($urandom_range(7) == 0) begin
            r.obend = r.odir ? t_coord'((int'(r.sy) + int'(r.ey)) / 2)
                             : t_coord'((int'(r.sx) + int'(r.ex)) / 2);
        end
        if ($urandom_range(4) == 0) begin
            // One request in five is made a reroute of the random old route above.
            r.action = ACT_REROUTE;
        end
        return r;
    endfunction

    initial begin
        t_route_req r;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_PLACE;
        req_ch.start_x = '0; req_ch.start_y = '0;
        req_ch.end_x = '0;   req_ch.end_y = '0;
        req_ch.old_direction = 1'b0; req_ch.old_bend = '0;
        req_ch.explore = 1'b0; req_ch.random_value = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = REG_WIDTH; cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the full grid, then on a 2 by 2 grid: corners, every action, out of range.
        calm_stretch = 1'b1;
        send_request('{ACT_PLACE, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 8'd255, 1'b0, 16'd0});
        send_request('{ACT_READ, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0});
        send_request('{ACT_REROUTE, 8'd3, 8'd3, 8'd3, 8'd3, 1'b1, 8'd9, 1'b0, 16'hFFFF});
        send_request('{ACT_PLACE, 8'd2, 8'd2, 8'd6, 8'd4, 1'b0, 8'd10, 1'b0, 16'd0});
        send_request('{ACT_PLACE, 8'd6, 8'd4, 8'd2, 8'd2, 1'b1, 8'd0, 1'b1, 16'd0});
        send_request('{ACT_REROUTE, 8'd2, 8'd2, 8'd6, 8'd4, 1'b0, 8'd10, 1'b0, 16'd0});
        send_request('{ACT_REROUTE, 8'd2, 8'd2, 8'd6, 8'd4, 1'b0, 8'd3, 1'b1, 16'hFFFF});
        send_request('{ACT_REROUTE, 8'd9, 8'd9, 8'd1, 8'd5, 1'b1, 8'd0, 1'b0, 16'h5555});
        send_request('{ACT_READ, 8'd4, 8'd2, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0});
        send_request('{ACT_UNUSED, 8'hAA, 8'h55, 8'hFF, 8'h0F, 1'b1, 8'hF0, 1'b1, 16'hAAAA});
        drain();
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        send_request('{ACT_PLACE, 8'd0, 8'd0, 8'd1, 8'd1, 1'b1, 8'd1, 1'b0, 16'd0});
        send_request('{ACT_PLACE, 8'd2, 8'd0, 8'd1, 8'd1, 1'b0, 8'd0, 1'b0, 16'd0});
        send_request('{ACT_PLACE, 8'd0, 8'd0, 8'd1, 8'd1, 1'b0, 8'd2, 1'b0, 16'd0});
        send_request('{ACT_REROUTE, 8'd1, 8'd1, 8'd0, 8'd0, 1'b1, 8'd1, 1'b0, 16'd0});
        send_request('{ACT_READ, 8'd0, 8'd2, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0});
        send_request('{ACT_READ, 8'd1, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0});
        drain();
        calm_stretch = 1'b0;

        // Random phases over several grid sizes, extremes among them.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin write_reg(REG_WIDTH, 16); write_reg(REG_HEIGHT, 12); end
                1: begin write_reg(REG_WIDTH, 511); write_reg(REG_HEIGHT, 256); end
                2: begin write_reg(REG_WIDTH, 3); write_reg(REG_HEIGHT, 40); end
                default: begin write_reg(REG_WIDTH, 256); write_reg(REG_HEIGHT, 511); end
            endcase
            if (phase == 1) begin
                // The receiver holds off while requests keep coming.
                hold_sink = 1'b1;
                fork
                    begin
                        repeat (3000) @(negedge i_clk);
                        hold_sink = 1'b0;
                    end
                join_none
            end
            calm_stretch = (phase == 2);
            for (n = 0; n < 32; n++) begin
                r = random_request((phase == 1 || phase == 3) ? 6 : 4);
                send_request(r);
            end
            drain();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
